// File: rtl/aps_pkg.sv
package aps_pkg;

    localparam int PRIO_W  = 16;
    localparam int RT_W    = 16;
    localparam int TOTAL_W = 20;
    localparam int SLOT_W  = 4;

    localparam logic [PRIO_W-1:0]  PRIO_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // one slot of the process table; empty slots are those at or above the fill count
    typedef struct packed {
        logic              done;
        logic [RT_W-1:0]   runtime;
        logic [PRIO_W-1:0] prio;
    } entry_t;

endpackage

// File: rtl/aps_if.sv
interface aps_req_if;
    import aps_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [PRIO_W-1:0] load_priority;
    logic [RT_W-1:0]   load_runtime;

    modport source (output valid, func, load_priority, load_runtime, input ready);
    modport sink   (input valid, func, load_priority, load_runtime, output ready);
endinterface

interface aps_rsp_if;
    import aps_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot;
    logic               ok;
    logic               completed;
    logic [TOTAL_W-1:0] remaining_total;

    modport source (output valid, slot, ok, completed, remaining_total, input ready);
    modport sink   (input valid, slot, ok, completed, remaining_total, output ready);
endinterface

// File: rtl/aps_table.sv
module aps_table #(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  aps_pkg::entry_t          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output aps_pkg::entry_t          rd_data
);
    import aps_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/aps_ctrl.sv
module aps_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    aps_req_if.sink                  req,
    aps_rsp_if.source                rsp,
    output logic                     mem_wr_en,
    output logic [$clog2(SLOTS)-1:0] mem_wr_addr,
    output aps_pkg::entry_t          mem_wr_data,
    output logic                     mem_rd_en,
    output logic [$clog2(SLOTS)-1:0] mem_rd_addr,
    input  aps_pkg::entry_t          mem_rd_data
);
    import aps_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    state_t state_reg, state_next;

    logic              func_reg;
    logic [PRIO_W-1:0] prio_in_reg;
    logic [RT_W-1:0]   rt_in_reg;

    logic [CW-1:0]      used_reg, used_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      pend_idx_reg;
    logic               found_reg, found_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    entry_t             best_reg, best_next;

    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_done_reg, out_done_next;

    logic               accept;
    logic               commit;
    logic               scan_busy;
    logic [TOTAL_W:0]   total_sum;
    logic [XW-1:0]      slot_ext;
    logic [RT_W-1:0]    rt_dec;
    logic [PRIO_W-1:0]  prio_inc;

    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);
    assign scan_busy = (state_reg == ST_SCAN) && (issue_reg < used_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.func == FUNC_TICK) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (!scan_busy && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        used_next      = used_reg;
        total_next     = total_reg;
        issue_next     = issue_reg;
        pend_next      = scan_busy;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_slot_next  = out_slot_reg;
        out_ok_next    = out_ok_reg;
        out_done_next  = out_done_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;
        mem_rd_en      = scan_busy;
        mem_rd_addr    = issue_reg[IW-1:0];
        total_sum      = {1'b0, total_reg} + {{(TOTAL_W + 1 - RT_W){1'b0}}, rt_in_reg};
        slot_ext       = '0;
        rt_dec         = (best_reg.runtime != '0) ? best_reg.runtime - 1'b1 : best_reg.runtime;
        prio_inc       = (best_reg.prio != PRIO_MAX) ? best_reg.prio + 1'b1 : best_reg.prio;

        if (accept)
        begin
            issue_next = '0;
            found_next = 1'b0;
        end

        if (scan_busy)
        begin
            issue_next = issue_reg + 1'b1;
        end

        // earliest slot wins a tie: only a strictly smaller number replaces the best
        if (pend_reg && !mem_rd_data.done &&
            (!found_reg || (mem_rd_data.prio < best_reg.prio)))
        begin
            found_next    = 1'b1;
            best_idx_next = pend_idx_reg;
            best_next     = mem_rd_data;
        end

        if (commit)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = '0;
            out_ok_next    = 1'b0;
            out_done_next  = 1'b0;
            if (func_reg == FUNC_LOAD)
            begin
                if ((rt_in_reg != '0) && (used_reg < SLOTS_C))
                begin
                    mem_wr_en        = 1'b1;
                    mem_wr_addr      = used_reg[IW-1:0];
                    mem_wr_data.done = 1'b0;
                    mem_wr_data.runtime = rt_in_reg;
                    mem_wr_data.prio = prio_in_reg;
                    used_next        = used_reg + 1'b1;
                    total_next       = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                    slot_ext         = XW'(used_reg[IW-1:0]);
                    out_slot_next    = slot_ext[SLOT_W-1:0];
                    out_ok_next      = 1'b1;
                end
            end
            else if (found_reg)
            begin
                mem_wr_en           = 1'b1;
                mem_wr_addr         = best_idx_reg;
                mem_wr_data.done    = (rt_dec == '0);
                mem_wr_data.runtime = rt_dec;
                mem_wr_data.prio    = prio_inc;
                if (total_reg != '0)
                begin
                    total_next = total_reg - 1'b1;
                end
                slot_ext      = XW'(best_idx_reg);
                out_slot_next = slot_ext[SLOT_W-1:0];
                out_ok_next   = 1'b1;
                out_done_next = (rt_dec == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            total_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            total_reg     <= total_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            prio_in_reg <= req.load_priority;
            rt_in_reg   <= req.load_runtime;
        end
        pend_idx_reg <= issue_reg[IW-1:0];
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        out_slot_reg <= out_slot_next;
        out_ok_reg   <= out_ok_next;
        out_done_reg <= out_done_next;
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.slot            = out_slot_reg;
    assign rsp.ok              = out_ok_reg;
    assign rsp.completed       = out_done_reg;
    assign rsp.remaining_total = total_reg;

endmodule

// File: rtl/aging_priority_scheduler_top.sv
// Aging priority scheduler. Processes are loaded into a table of SLOTS slots
// in arrival order (slots are never reused); a tick runs the ready process with
// the smallest priority number, ties going to the earliest-loaded slot, then
// ages it by one and charges it one time unit. Each request gives exactly one
// response. A load is answered without reading the table; a tick's response
// comes only after the whole filled part of the table has been read, because
// the table sits in a synchronous memory with one read and one write port
// that is scanned one entry per cycle, and the last read must return before
// the result is formed. A new request is taken while the previous response is
// still waiting on the output register, but its result is held back until that
// response leaves, so a stalled output can delay the next response. Occupancy
// is tracked by a fill count, so no memory clearing is needed after reset.
module aging_priority_scheduler_top #(
    parameter int SLOTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    aps_req_if.sink   req,
    aps_rsp_if.source rsp
);
    import aps_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    entry_t        mem_wr_data;
    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    entry_t        mem_rd_data;

    aps_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    aps_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// File: rtl/aps_checker.sv
module aps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [aps_pkg::SLOT_W-1:0]  rsp_slot,
    input logic                        rsp_ok,
    input logic                        rsp_completed,
    input logic [aps_pkg::TOTAL_W-1:0] rsp_remaining_total
);
    import aps_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled response keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_ok)
            && $stable(rsp_completed) && $stable(rsp_remaining_total))
        else $error("response changed while stalled");

    // no response without a request behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without outstanding request");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_slot == '0 && !rsp_completed)
        else $error("refused request carries slot or completion");

    // at most one request waits behind a response still being held
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !req_ready)
        else $error("request taken with two outstanding");

endmodule

bind aging_priority_scheduler_top aps_checker u_aps_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_slot            (rsp.slot),
    .rsp_ok              (rsp.ok),
    .rsp_completed       (rsp.completed),
    .rsp_remaining_total (rsp.remaining_total)
);
